### sv/vcpv_pkg.sv
package vcpv_pkg;

   // Item kinds on the request channel.
   typedef enum logic [1:0] {
      KIND_READ       = 2'd0,
      KIND_WRITE_BYTE = 2'd1,
      KIND_WRITE_WORD = 2'd2,
      KIND_TICK       = 2'd3
   } kind_type;

   // Timer constants.
   localparam int FRAME_CYCLES    = 261379;
   localparam int BLANK_CYCLES    = 22403;
   localparam int BLANK_DELAY     = 497;
   localparam int PALETTE_ENTRIES = 256;

   localparam int FRAME_W   = 18;
   localparam int BLANK_W   = 15;
   localparam int DELAY_W   = 9;
   localparam int PAL_IDX_W = $clog2(PALETTE_ENTRIES);

   // Address regions, taken from address bits 19..16.
   localparam logic [3:0] REGION_TIMING = 4'h8;
   localparam logic [3:0] REGION_PORT   = 4'h9;
   localparam logic [3:0] REGION_IRQ    = 4'ha;
   localparam logic [3:0] REGION_STATUS = 4'hd;

   // Palette port registers, taken from address bits 3..2.
   localparam logic [1:0] PORT_NONE      = 2'd0;
   localparam logic [1:0] PORT_POINTER_A = 2'd1;
   localparam logic [1:0] PORT_DATA      = 2'd2;
   localparam logic [1:0] PORT_POINTER_B = 2'd3;

   // Byte lanes.
   localparam logic [1:0] LANE_PORT   = 2'd0;
   localparam logic [1:0] LANE_ZERO_A = 2'd1;
   localparam logic [1:0] LANE_ZERO_B = 2'd2;
   localparam logic [1:0] LANE_STATUS = 2'd3;

   // Timing register that carries the depth field.
   localparam logic [3:0] TIMING_DEPTH_REG = 4'hf;

   // Component sequencer steps.
   localparam logic [1:0] STEP_RED   = 2'd0;
   localparam logic [1:0] STEP_GREEN = 2'd1;
   localparam logic [1:0] STEP_BLUE  = 2'd2;

   localparam logic [7:0] BLACK_ENTRY = 8'd128;
   localparam logic [7:0] BYTE_IDLE   = 8'hff;

   // Palette contents after reset: a grey ramp falling from white, with one
   // black entry in the middle.
   function automatic logic [23:0] pal_reset_entry(input logic [PAL_IDX_W-1:0] idx);
      logic [7:0] grey;
      grey = ~idx;
      if (idx == BLACK_ENTRY) begin
         return 24'h000000;
      end
      return {grey, grey, grey};
   endfunction

endpackage

### sv/video_card_palette_and_vblank.sv
// Register side of an indexed-colour video card.
//
// Request channel (req_valid/req_ready): one word per bus access or time tick,
// carrying kind, address, write data and elapsed cycles. Response channel
// (rsp_valid/rsp_ready): exactly one word per request, with the byte read
// (0xff for writes and ticks), the interrupt level and the depth mode as they
// stand after that request.
//
// A request accepted at one edge has its response registered at that edge and
// shown from then on. Throughput is one request per cycle while the receiver
// takes each response; all the work is a single pass of short logic into the
// response register. The palette is a 256 x 24 memory whose registered read
// port always follows the next value of the palette pointer, so the entry at
// the pointer is ready when the next request arrives.
//
// Reset clears the timing state, the pointer and sequencer, the interrupt and
// the per-entry valid bits at once; entries not yet written read as the reset
// grey ramp, so no clearing pass is needed. When the receiver stalls with a
// response waiting, req_ready drops until that response is taken; otherwise a
// request is taken while the previous response leaves in the same cycle.
module video_card_palette_and_vblank (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [19:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic [15:0] req_tick_cycles,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq,
   output logic [1:0]  rsp_depth_mode
);

   localparam int IW = vcpv_pkg::PAL_IDX_W;

   // Control state.
   logic [1:0]                      depth_ff, depth_in;
   logic [IW-1:0]                   ptr_ff, ptr_in;
   logic [1:0]                      step_ff, step_in;
   logic                            vbl_en_ff, vbl_en_in;
   logic                            irq_ff, irq_in;
   logic [vcpv_pkg::FRAME_W-1:0]    frame_ff, frame_in;
   logic [vcpv_pkg::BLANK_W-1:0]    blank_ff, blank_in;
   logic [vcpv_pkg::DELAY_W-1:0]    delay_ff, delay_in;
   logic [vcpv_pkg::PALETTE_ENTRIES-1:0] pal_valid_ff;

   // Component latches for red and green; blue goes straight to the palette.
   logic [7:0]  latch_r_ff, latch_r_in;
   logic [7:0]  latch_g_ff, latch_g_in;

   // Palette memory.
   logic [23:0] pal_mem [vcpv_pkg::PALETTE_ENTRIES];
   logic [23:0] pal_q_ff;
   logic        pal_we;
   logic [23:0] pal_wdata;
   logic [23:0] pal_entry;

   // Response register.
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;
   logic        rsp_irq_ff;
   logic [1:0]  rsp_depth_ff;
   logic [7:0]  read_byte;

   logic              accept;
   vcpv_pkg::kind_type kind;
   logic [3:0]        region;
   logic [1:0]        lane;
   logic [1:0]        port_reg;
   logic              in_port;
   logic              port_write;
   logic [7:0]        port_byte;
   logic [7:0]        port_val;
   logic [7:0]        timing_stored;
   logic [15:0]       cyc;
   logic [15:0]       delay_over;
   logic [vcpv_pkg::FRAME_W-1:0] frame_over;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign kind     = vcpv_pkg::kind_type'(req_kind);
   assign region   = req_address[19:16];
   assign lane     = req_address[1:0];
   assign port_reg = req_address[3:2];
   assign in_port  = (region == vcpv_pkg::REGION_PORT) && (req_address[15:5] == 11'd0);
   assign cyc      = req_tick_cycles;

   assign pal_entry = pal_valid_ff[ptr_ff] ? pal_q_ff : vcpv_pkg::pal_reset_entry(ptr_ff);

   assign port_write = in_port && ((kind == vcpv_pkg::KIND_WRITE_WORD) ||
                                   ((kind == vcpv_pkg::KIND_WRITE_BYTE) &&
                                    (lane == vcpv_pkg::LANE_PORT)));
   assign port_byte  = (kind == vcpv_pkg::KIND_WRITE_WORD) ? req_write_data[31:24]
                                                           : req_write_data[7:0];
   assign port_val   = ~port_byte;

   // Byte writes on the middle lanes store all ones.
   always_comb begin
      if (kind == vcpv_pkg::KIND_WRITE_BYTE &&
          (lane == vcpv_pkg::LANE_ZERO_A || lane == vcpv_pkg::LANE_ZERO_B)) begin
         timing_stored = 8'hff;
      end else begin
         timing_stored = ~req_write_data[7:0];
      end
   end

   always_comb begin
      depth_in   = depth_ff;
      ptr_in     = ptr_ff;
      step_in    = step_ff;
      vbl_en_in  = vbl_en_ff;
      irq_in     = irq_ff;
      frame_in   = frame_ff;
      blank_in   = blank_ff;
      delay_in   = delay_ff;
      latch_r_in = latch_r_ff;
      latch_g_in = latch_g_ff;
      pal_we     = 1'b0;
      pal_wdata  = {latch_r_ff, latch_g_ff, port_val};
      read_byte  = vcpv_pkg::BYTE_IDLE;
      delay_over = '0;
      frame_over = '0;

      if (accept) begin
         unique case (kind)
            vcpv_pkg::KIND_READ: begin
               if (in_port && lane == vcpv_pkg::LANE_PORT) begin
                  unique case (port_reg) inside
                     vcpv_pkg::PORT_POINTER_A, vcpv_pkg::PORT_POINTER_B: begin
                        read_byte = ~ptr_ff;
                     end
                     vcpv_pkg::PORT_DATA: begin
                        case (step_ff)
                           vcpv_pkg::STEP_RED:   read_byte = ~pal_entry[23:16];
                           vcpv_pkg::STEP_GREEN: read_byte = ~pal_entry[15:8];
                           default:              read_byte = ~pal_entry[7:0];
                        endcase
                        if (step_ff == vcpv_pkg::STEP_BLUE) begin
                           step_in = vcpv_pkg::STEP_RED;
                           ptr_in  = ptr_ff + 1'b1;
                        end else begin
                           step_in = step_ff + 2'd1;
                        end
                     end
                     default: begin
                        read_byte = vcpv_pkg::BYTE_IDLE;
                     end
                  endcase
               end else if (region == vcpv_pkg::REGION_STATUS &&
                            lane == vcpv_pkg::LANE_STATUS) begin
                  read_byte = (blank_ff != '0) ? 8'h00 : 8'hff;
               end
            end
            vcpv_pkg::KIND_WRITE_BYTE, vcpv_pkg::KIND_WRITE_WORD: begin
               if (region == vcpv_pkg::REGION_TIMING) begin
                  // Only the depth field of the timing registers is visible.
                  if (req_address[5:2] == vcpv_pkg::TIMING_DEPTH_REG) begin
                     depth_in = timing_stored[5:4];
                  end
               end else if (port_write) begin
                  unique case (port_reg) inside
                     vcpv_pkg::PORT_POINTER_A, vcpv_pkg::PORT_POINTER_B: begin
                        ptr_in  = port_val;
                        step_in = vcpv_pkg::STEP_RED;
                     end
                     vcpv_pkg::PORT_DATA: begin
                        case (step_ff)
                           vcpv_pkg::STEP_RED: begin
                              latch_r_in = port_val;
                              step_in    = vcpv_pkg::STEP_GREEN;
                           end
                           vcpv_pkg::STEP_GREEN: begin
                              latch_g_in = port_val;
                              step_in    = vcpv_pkg::STEP_BLUE;
                           end
                           default: begin
                              pal_we  = 1'b1;
                              ptr_in  = ptr_ff + 1'b1;
                              step_in = vcpv_pkg::STEP_RED;
                           end
                        endcase
                     end
                     default: begin
                        step_in = step_ff;
                     end
                  endcase
               end else if (region == vcpv_pkg::REGION_IRQ) begin
                  if (req_address[2]) begin
                     vbl_en_in = 1'b0;
                  end else begin
                     vbl_en_in = 1'b1;
                     irq_in    = 1'b0;
                  end
               end
            end
            vcpv_pkg::KIND_TICK: begin
               if ({1'b0, blank_ff} > cyc) begin
                  blank_in = vcpv_pkg::BLANK_W'({1'b0, blank_ff} - cyc);
               end else begin
                  blank_in = '0;
               end
               if (delay_ff != '0) begin
                  if (16'(delay_ff) > cyc) begin
                     delay_in = delay_ff - cyc[vcpv_pkg::DELAY_W-1:0];
                  end else begin
                     delay_over = cyc - 16'(delay_ff);
                     delay_in   = '0;
                     if (delay_over >= 16'(vcpv_pkg::BLANK_CYCLES)) begin
                        blank_in = '0;
                     end else begin
                        blank_in = vcpv_pkg::BLANK_W'(16'(vcpv_pkg::BLANK_CYCLES) - delay_over);
                     end
                  end
               end
               // A tick never exceeds a whole frame, so the overshoot is
               // already below the frame length.
               if (vcpv_pkg::FRAME_W'(cyc) >= frame_ff) begin
                  frame_over = vcpv_pkg::FRAME_W'(cyc) - frame_ff;
                  frame_in   = vcpv_pkg::FRAME_W'(vcpv_pkg::FRAME_CYCLES) - frame_over;
                  delay_in   = vcpv_pkg::DELAY_W'(vcpv_pkg::BLANK_DELAY);
                  if (vbl_en_ff) begin
                     irq_in = 1'b1;
                  end
               end else begin
                  frame_in = frame_ff - vcpv_pkg::FRAME_W'(cyc);
               end
            end
            default: begin
               read_byte = vcpv_pkg::BYTE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         ptr_ff       <= '0;
         step_ff      <= vcpv_pkg::STEP_RED;
         vbl_en_ff    <= 1'b0;
         irq_ff       <= 1'b0;
         frame_ff     <= vcpv_pkg::FRAME_W'(vcpv_pkg::FRAME_CYCLES);
         blank_ff     <= '0;
         delay_ff     <= '0;
         pal_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff  <= depth_in;
         ptr_ff    <= ptr_in;
         step_ff   <= step_in;
         vbl_en_ff <= vbl_en_in;
         irq_ff    <= irq_in;
         frame_ff  <= frame_in;
         blank_ff  <= blank_in;
         delay_ff  <= delay_in;
         if (pal_we) begin
            pal_valid_ff[ptr_ff] <= 1'b1;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      latch_r_ff <= latch_r_in;
      latch_g_ff <= latch_g_in;
      if (accept) begin
         rsp_data_ff  <= read_byte;
         rsp_irq_ff   <= irq_in;
         rsp_depth_ff <= depth_in;
      end
   end

   // A write always moves the pointer on, so the read address never meets
   // the write address in the same cycle.
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[ptr_ff] <= pal_wdata;
      end
      pal_q_ff <= pal_mem[ptr_in];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_irq        = rsp_irq_ff;
   assign rsp_depth_mode = rsp_depth_ff;

endmodule

### sv/vcpv_checker.sv
module vcpv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_irq,
   input logic [1:0]  rsp_depth_mode
);

   // A held response word keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
                                  $stable(rsp_irq) && $stable(rsp_depth_mode))
      else $error("response changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every accepted request shows its response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // Writes and ticks return the idle byte.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind != vcpv_pkg::KIND_READ) |=>
         rsp_read_data == vcpv_pkg::BYTE_IDLE)
      else $error("non-read request returned data");

   // With no response waiting the block must take a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty response register");

endmodule

bind video_card_palette_and_vblank vcpv_checker u_vcpv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_data  (rsp_read_data),
   .rsp_irq        (rsp_irq),
   .rsp_depth_mode (rsp_depth_mode)
);
